>>> src/ufmm_pkg.sv
// Shared types and constants of the ultrasonic frame median monitor.
package ufmm_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_BURST = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_DIS  = 2'd2;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_NO_ECHO = 2'd1;
    localparam logic [1:0] REG_DISABLE = 2'd2;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [3:0]  RESET_TIMEOUT  = 4'd10;
    localparam logic [15:0] RESET_DISTANCE = 16'd4500;
    localparam logic [4:0]  TIMEOUT_MAX    = 5'd31;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] channel;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  out_channel;
        logic [15:0] distance;
        logic [1:0]  status;
        logic        fresh;
        logic        last;
    } res_t;

endpackage

>>> src/ufmm_fifo.sv
// Two-entry command queue between the front and back parts.
module ufmm_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ufmm_pkg::cmd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ufmm_pkg::cmd_t out_data
);
    import ufmm_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> src/ufmm_front.sv
// Front part: accepts input transfers and drops those that cause no result.
module ufmm_front #(
    parameter int CHANNELS = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ufmm_pkg::cmd_t s_cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output ufmm_pkg::cmd_t q_cmd
);
    import ufmm_pkg::*;

    logic keep;

    always_comb begin
        keep = 1'b0;
        unique case (s_cmd.opcode)
            OP_TICK: keep = 1'b1;
            OP_BYTE, OP_BURST: keep = ({30'd0, s_cmd.channel} < CHANNELS);
            default: keep = 1'b0;
        endcase
    end

    ufmm_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid && keep), .in_ready(s_ready),
        .in_data(s_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cmd)
    );
endmodule

>>> src/ufmm_back.sv
// Back part: channel state, median filter and result sequencing.
module ufmm_back #(
    parameter int CHANNELS      = 3,
    parameter int HISTORY_DEPTH = 5,
    parameter int BURST_BYTES   = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  ufmm_pkg::cmd_t q_cmd,
    input  logic [3:0]    timeout_limit,
    input  logic [15:0]   no_echo_distance,
    input  logic [2:0]    disable_mask,
    output logic          r_valid,
    input  logic          r_ready,
    output ufmm_pkg::res_t r_data
);
    import ufmm_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BW = $clog2(BURST_BYTES + 1);
    localparam int MID = HISTORY_DEPTH / 2;

    logic [23:0]      win_reg   [CHANNELS];
    logic [BW-1:0]    cnt_reg   [CHANNELS];
    logic             taken_reg [CHANNELS];
    logic [15:0]      hist_reg  [CHANNELS][HISTORY_DEPTH];
    logic [15:0]      dist_reg  [CHANNELS];
    logic             err_reg   [CHANNELS];
    logic [4:0]       tmo_reg   [CHANNELS];

    // Stage 1: history pushed, median pending.
    logic             med_pend_reg;
    logic [CW-1:0]    med_ch_reg;
    // Tick emission sequencer.
    logic             tick_busy_reg;
    logic [CW-1:0]    tick_idx_reg;
    // Output register.
    logic             r_valid_reg;
    res_t             r_data_reg;

    logic [CW-1:0] ch;
    logic          dis_c;
    logic [7:0]    b0, b1, b2;
    logic          frame_hit;
    logic          out_free;
    logic          take;
    logic [15:0]   median;
    logic [15:0]   hv [HISTORY_DEPTH];

    assign ch    = q_cmd.channel[CW-1:0];
    assign dis_c = (q_cmd.channel < 2'd3) && disable_mask[q_cmd.channel];
    assign b0 = win_reg[ch][23:16];
    assign b1 = win_reg[ch][15:8];
    assign b2 = win_reg[ch][7:0];
    assign frame_hit = (q_cmd.opcode == OP_BYTE) && !dis_c
        && ({{(32-BW){1'b0}}, cnt_reg[ch]} < BURST_BYTES) && !taken_reg[ch]
        && ({{(32-BW){1'b0}}, cnt_reg[ch]} >= 3) && (b0 == SYNC_BYTE)
        && (8'(b0 + b1 + b2) == q_cmd.data_byte);

    assign out_free = !r_valid_reg || r_ready;
    // A frame waits for its median, a tick for its sequencer; the rest is direct.
    assign take    = q_valid && out_free && !med_pend_reg && !tick_busy_reg;
    assign q_ready = take;

    // Median by rank count over the history row.
    always_comb begin
        int lt, le;
        median = 16'd0;
        for (int i = 0; i < HISTORY_DEPTH; i++) hv[i] = hist_reg[med_ch_reg][i];
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < HISTORY_DEPTH; j++) begin
                if (hv[j] < hv[i]) lt++;
                if (hv[j] <= hv[i]) le++;
            end
            if (lt <= MID && le > MID) median = hv[i];
        end
    end

    function automatic logic [1:0] stat_of(input logic d, input logic e);
        return d ? ST_DIS : (e ? ST_ERR : ST_RUN);
    endfunction

    assign r_valid = r_valid_reg;
    assign r_data  = r_data_reg;

    always_ff @(posedge aclk) begin
        logic [15:0] md;
        logic [CW:0] ti;
        logic        td;
        if (r_valid_reg && r_ready) r_valid_reg <= 1'b0;
        md = (median == 16'd0) ? no_echo_distance : median;
        if (med_pend_reg && out_free) begin
            dist_reg[med_ch_reg] <= md;
            med_pend_reg <= 1'b0;
            r_valid_reg <= 1'b1;
            r_data_reg <= '{out_channel: 2'(med_ch_reg), distance: md,
                            status: ST_RUN, fresh: 1'b1, last: 1'b1};
        end
        if (tick_busy_reg && out_free) begin
            ti = {1'b0, tick_idx_reg};
            td = (ti < 3) && disable_mask[2'(ti)];
            r_valid_reg <= 1'b1;
            r_data_reg <= '{out_channel: 2'(tick_idx_reg),
                            distance: dist_reg[tick_idx_reg],
                            status: stat_of(td, err_reg[tick_idx_reg]),
                            fresh: 1'b0,
                            last: ({{(31-CW){1'b0}}, ti} == CHANNELS - 1)};
            if ({{(31-CW){1'b0}}, ti} == CHANNELS - 1) tick_busy_reg <= 1'b0;
            else tick_idx_reg <= tick_idx_reg + 1'b1;
        end
        if (take) begin
            unique case (q_cmd.opcode)
                OP_TICK: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (!((i < 3) && disable_mask[i]) && !err_reg[i]) begin
                            if (tmo_reg[i] != TIMEOUT_MAX) tmo_reg[i] <= tmo_reg[i] + 5'd1;
                            if (((tmo_reg[i] == TIMEOUT_MAX) ? tmo_reg[i]
                                 : tmo_reg[i] + 5'd1) > {1'b0, timeout_limit})
                                err_reg[i] <= 1'b1;
                        end
                    end
                    tick_busy_reg <= 1'b1;
                    tick_idx_reg  <= '0;
                end
                OP_BURST: begin
                    cnt_reg[ch]   <= '0;
                    taken_reg[ch] <= 1'b0;
                    if (dis_c) tmo_reg[ch] <= '0;
                    r_valid_reg <= 1'b1;
                    r_data_reg <= '{out_channel: q_cmd.channel, distance: dist_reg[ch],
                                    status: stat_of(dis_c, err_reg[ch]),
                                    fresh: 1'b0, last: 1'b1};
                end
                default: begin
                    if (dis_c) begin
                        tmo_reg[ch] <= '0;
                    end else if ({{(32-BW){1'b0}}, cnt_reg[ch]} < BURST_BYTES) begin
                        cnt_reg[ch] <= cnt_reg[ch] + 1'b1;
                        win_reg[ch] <= {win_reg[ch][15:0], q_cmd.data_byte};
                    end
                    if (frame_hit) begin
                        for (int k = 0; k < HISTORY_DEPTH - 1; k++)
                            hist_reg[ch][k] <= hist_reg[ch][k+1];
                        hist_reg[ch][HISTORY_DEPTH-1] <= {b1, b2};
                        tmo_reg[ch]   <= '0;
                        err_reg[ch]   <= 1'b0;
                        taken_reg[ch] <= 1'b1;
                        med_pend_reg  <= 1'b1;
                        med_ch_reg    <= ch;
                    end else begin
                        r_valid_reg <= 1'b1;
                        r_data_reg <= '{out_channel: q_cmd.channel,
                                        distance: dist_reg[ch],
                                        status: stat_of(dis_c, err_reg[ch]),
                                        fresh: 1'b0, last: 1'b1};
                    end
                end
            endcase
        end
        if (!aresetn) begin
            r_valid_reg   <= 1'b0;
            med_pend_reg  <= 1'b0;
            tick_busy_reg <= 1'b0;
            tick_idx_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                cnt_reg[i]   <= '0;
                taken_reg[i] <= 1'b0;
                dist_reg[i]  <= RESET_DISTANCE;
                err_reg[i]   <= 1'b0;
                tmo_reg[i]   <= '0;
                for (int k = 0; k < HISTORY_DEPTH; k++) hist_reg[i][k] <= '0;
            end
        end
    end
endmodule

>>> src/ultrasonic_frame_median_monitor.sv
// Top level of the ultrasonic frame median monitor.
// Input transfers on s_axis carry sensor bytes, burst ends and watchdog
// ticks. A byte or burst end for a valid channel yields one result on
// m_axis; a tick yields one result per channel, the last one with tlast.
// Opcode 3 and out-of-range channels yield nothing and are dropped.
// A two-entry queue decouples input from the result side, and results sit
// in an output register, so input keeps flowing while a result waits.
// Bytes and burst ends go through the queue to the output register; a byte
// that completes a frame first shifts the history, then sends its median.
// A tick holds the result port until every channel has its result. With
// m_axis_tready high, sustained rate is one input per cycle but for those.
// Reset clears channel state but the byte window, sets each distance to
// 4500, and restores the configuration registers to their defaults.
// When m_axis_tready is low, results hold and the queue fills, after which
// s_axis_tready drops. Configuration is written through cfg_we.
module ultrasonic_frame_median_monitor #(
    parameter int CHANNELS      = 3,
    parameter int HISTORY_DEPTH = 5,
    parameter int BURST_BYTES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // opcode[1:0], channel[3:2], data_byte[11:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_channel[1:0], distance[17:2], status[19:18]
    output logic        m_axis_tuser,  // fresh
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import ufmm_pkg::*;

    cmd_t       s_cmd, q_cmd;
    res_t       res;
    logic       q_valid, q_ready;
    logic [3:0] tmo_lim_reg;
    logic [15:0] no_echo_reg;
    logic [2:0] dis_reg;

    assign s_cmd = '{opcode: s_axis_tdata[1:0], channel: s_axis_tdata[3:2],
                     data_byte: s_axis_tdata[11:4]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmo_lim_reg <= RESET_TIMEOUT;
            no_echo_reg <= RESET_DISTANCE;
            dis_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TIMEOUT: tmo_lim_reg <= cfg_wdata[3:0];
                REG_NO_ECHO: no_echo_reg <= cfg_wdata;
                REG_DISABLE: dis_reg     <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    ufmm_front #(.CHANNELS(CHANNELS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_cmd(s_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    ufmm_back #(.CHANNELS(CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH),
                .BURST_BYTES(BURST_BYTES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .timeout_limit(tmo_lim_reg), .no_echo_distance(no_echo_reg),
        .disable_mask(dis_reg),
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data(res)
    );

    assign m_axis_tdata = {4'd0, res.status, res.distance, res.out_channel};
    assign m_axis_tuser = res.fresh;
    assign m_axis_tlast = res.last;
endmodule
